// File: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define TEM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check that also runs through reset
`define TEM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/tem_pkg.sv
`timescale 1ns / 1ps

package tem_pkg;

    // field widths
    localparam int META_W     = 24;               // signed bearing, 18.6
    localparam int DIM_W      = 23;               // unsigned size or advance, 17.6
    localparam int FRAC_W     = 6;                // fraction bits of 18.6 and 17.6
    localparam int PX_W       = META_W - FRAC_W;  // floored bearing in pixels
    localparam int CPX_W      = DIM_W + 1 - FRAC_W; // ceiled size in pixels
    localparam int BOX_W      = 20;               // glyph box coordinates
    localparam int ST_W       = 32;               // running state
    localparam int SUM_W      = 34;               // headroom for state arithmetic
    localparam int OUT_W      = 24;               // result fields
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // rounding constant for ceiling to whole pixels
    localparam logic [DIM_W:0] CEIL_ADD = (DIM_W + 1)'((1 << FRAC_W) - 1);

    // saturation limits, carried at the wide arithmetic width
    localparam logic signed [SUM_W-1:0] ST_MAX_W  = SUM_W'((64'sd1 <<< (ST_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] ST_MIN_W  = SUM_W'(-(64'sd1 <<< (ST_W - 1)));
    localparam logic signed [SUM_W-1:0] OUT_MAX_W = SUM_W'((64'sd1 <<< OUT_W) - 64'sd1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOLD_ON       = 4'd0,
        CFG_ITALIC_ON     = 4'd1,
        CFG_BOLD_OVERHANG = 4'd2,
        CFG_ITALIC_BUMP   = 4'd3
    } cfg_index_t;

    // style settings
    typedef struct packed {
        logic                  bold_on;
        logic                  italic_on;
        logic [CFG_DATA_W-1:0] bold_overhang;
        logic [CFG_DATA_W-1:0] italic_bump;
    } tem_cfg_t;

    // one glyph's box in whole pixels
    typedef struct packed {
        logic signed [BOX_W-1:0] min_x;
        logic signed [BOX_W-1:0] max_x;
        logic signed [BOX_W-1:0] min_y;
        logic signed [BOX_W-1:0] max_y;
        logic signed [BOX_W-1:0] adv;
    } tem_box_t;

    // clamp a wide value to the signed state range
    function automatic logic signed [ST_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [ST_W-1:0] r;
        if (v > ST_MAX_W) begin
            r = ST_MAX_W[ST_W-1:0];
        end else if (v < ST_MIN_W) begin
            r = ST_MIN_W[ST_W-1:0];
        end else begin
            r = v[ST_W-1:0];
        end
        return r;
    endfunction

    // clamp a difference to the result range
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > OUT_MAX_W) begin
            r = OUT_MAX_W[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/text_extent_measure.sv
`timescale 1ns / 1ps

// Pixel extent of a string of glyphs.
// Input channel (s_valid / s_ready): one glyph's 18.6 / 17.6 metrics per item, with
// s_last_glyph high on the final glyph of a string.
// Result channel (m_valid / m_ready): one item per string, carrying the width
// and height in pixels, clamped to the 24-bit range.
// Configuration channel (cfg_valid / cfg_ready): cfg_index selects bold on,
// italic on, bold overhang or italic bump; other indexes are dropped. Write
// only while no string is in flight. cfg_ready is always high.
// Throughput: one glyph per cycle, except while a last glyph is held back by a
// waiting result. The pen and bound registers update as each glyph leaves the
// input register; a last glyph's extent goes from the input register through
// the bounds into the result register that drives m_valid.
// Reset clears the style settings, the pen, the bounds and both valids.
// When the receiver stalls with a result waiting, glyphs keep flowing until a
// further last glyph reaches the input register; it then waits there and
// s_ready drops until the waiting result is taken.
module text_extent_measure (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tem_pkg::META_W-1:0]   s_bearing_x,
    input  logic        [tem_pkg::DIM_W-1:0]    s_glyph_width,
    input  logic signed [tem_pkg::META_W-1:0]   s_bearing_y,
    input  logic        [tem_pkg::DIM_W-1:0]    s_glyph_height,
    input  logic        [tem_pkg::DIM_W-1:0]    s_pen_advance,
    input  logic                                s_last_glyph,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [tem_pkg::OUT_W-1:0]    m_text_width,
    output logic        [tem_pkg::OUT_W-1:0]    m_text_height,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [tem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [tem_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tem_pkg::*;

    tem_cfg_t                cfg_reg, cfg_next;
    logic                    in_valid_reg, in_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [META_W-1:0] bx_reg, by_reg;
    logic        [DIM_W-1:0]  gw_reg, gh_reg, adv_reg;
    logic                    last_reg;
    logic [OUT_W-1:0]        width_reg, height_reg;
    logic                    stall, fire, load;
    tem_box_t                box;
    logic [OUT_W-1:0]        width_calc, height_calc;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_BOLD_ON:       cfg_next.bold_on       = cfg_data[0];
                CFG_ITALIC_ON:     cfg_next.italic_on     = cfg_data[0];
                CFG_BOLD_OVERHANG: cfg_next.bold_overhang = cfg_data;
                CFG_ITALIC_BUMP:   cfg_next.italic_bump   = cfg_data;
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // a last glyph waits only while the result register is still held
    assign stall   = in_valid_reg && last_reg && out_valid_reg && !m_ready;
    assign fire    = in_valid_reg && !stall;
    assign s_ready = !in_valid_reg || !stall;
    assign load    = s_valid && s_ready;

    // handshake state
    always_comb begin
        in_valid_next = in_valid_reg;
        if (load) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input item register
    always_ff @(posedge aclk) begin
        if (load) begin
            bx_reg   <= s_bearing_x;
            gw_reg   <= s_glyph_width;
            by_reg   <= s_bearing_y;
            gh_reg   <= s_glyph_height;
            adv_reg  <= s_pen_advance;
            last_reg <= s_last_glyph;
        end
    end

    // glyph box in whole pixels
    tem_glyph_box u_box (
        .bearing_x    (bx_reg),
        .glyph_width  (gw_reg),
        .bearing_y    (by_reg),
        .glyph_height (gh_reg),
        .pen_advance  (adv_reg),
        .cfg          (cfg_reg),
        .box          (box)
    );

    // running pen and bounds
    tem_extent_acc u_acc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (fire),
        .last        (last_reg),
        .box         (box),
        .cfg         (cfg_reg),
        .text_width  (width_calc),
        .text_height (height_calc)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (fire && last_reg) begin
            width_reg  <= width_calc;
            height_reg <= height_calc;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_text_width  = width_reg;
    assign m_text_height = height_reg;

endmodule

// File: hdl/tem_glyph_box.sv
`timescale 1ns / 1ps

module tem_glyph_box (
    input  logic signed [tem_pkg::META_W-1:0] bearing_x,
    input  logic        [tem_pkg::DIM_W-1:0]  glyph_width,
    input  logic signed [tem_pkg::META_W-1:0] bearing_y,
    input  logic        [tem_pkg::DIM_W-1:0]  glyph_height,
    input  logic        [tem_pkg::DIM_W-1:0]  pen_advance,
    input  tem_pkg::tem_cfg_t                 cfg,
    output tem_pkg::tem_box_t                 box
);
    import tem_pkg::*;

    logic signed [PX_W-1:0]  bx_px;
    logic signed [PX_W-1:0]  by_px;
    logic        [DIM_W:0]   w_rnd;
    logic        [DIM_W:0]   h_rnd;
    logic        [DIM_W:0]   a_rnd;
    logic signed [BOX_W-1:0] left;
    logic signed [BOX_W-1:0] top;
    logic signed [BOX_W-1:0] cw;
    logic signed [BOX_W-1:0] ch;
    logic signed [BOX_W-1:0] ca;
    logic signed [BOX_W-1:0] style_px;

    // floor the bearings: drop the fraction bits of the signed value
    assign bx_px = bearing_x[META_W-1:FRAC_W];
    assign by_px = bearing_y[META_W-1:FRAC_W];
    assign left  = BOX_W'(bx_px);
    assign top   = BOX_W'(by_px);

    // ceil the sizes and the advance
    assign w_rnd = {1'b0, glyph_width}  + CEIL_ADD;
    assign h_rnd = {1'b0, glyph_height} + CEIL_ADD;
    assign a_rnd = {1'b0, pen_advance}  + CEIL_ADD;
    assign cw    = BOX_W'(w_rnd[DIM_W:FRAC_W]);
    assign ch    = BOX_W'(h_rnd[DIM_W:FRAC_W]);
    assign ca    = BOX_W'(a_rnd[DIM_W:FRAC_W]);

    // extra right-edge pixels for bold and italic
    assign style_px = BOX_W'(cfg.bold_on   ? cfg.bold_overhang : '0)
                    + BOX_W'(cfg.italic_on ? cfg.italic_bump   : '0);

    // assemble the box
    assign box.min_x = left;
    assign box.max_x = left + cw + style_px;
    assign box.max_y = top;
    assign box.min_y = top - ch;
    assign box.adv   = ca;

endmodule

// File: hdl/tem_extent_acc.sv
`timescale 1ns / 1ps

module tem_extent_acc (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       last,
    input  tem_pkg::tem_box_t          box,
    input  tem_pkg::tem_cfg_t          cfg,
    output logic [tem_pkg::OUT_W-1:0]  text_width,
    output logic [tem_pkg::OUT_W-1:0]  text_height
);
    import tem_pkg::*;

    logic signed [ST_W-1:0]  pen_x_reg, pen_x_next;
    logic signed [ST_W-1:0]  min_x_reg, min_x_next;
    logic signed [ST_W-1:0]  max_x_reg, max_x_next;
    logic signed [ST_W-1:0]  min_y_reg, min_y_next;
    logic signed [ST_W-1:0]  max_y_reg, max_y_next;

    logic signed [ST_W-1:0]  pen_upd, min_x_upd, max_x_upd, min_y_upd, max_y_upd;
    logic signed [ST_W-1:0]  pen_bold;
    logic signed [BOX_W-1:0] g_min_x, g_max_x, g_min_y, g_max_y, g_adv, reach;
    logic signed [SUM_W-1:0] pen_w, bo_w, adv_w, z_min, z_max;
    logic signed [SUM_W-1:0] width_diff, height_diff;

    assign g_min_x = box.min_x;
    assign g_max_x = box.max_x;
    assign g_min_y = box.min_y;
    assign g_max_y = box.max_y;
    assign g_adv   = box.adv;

    assign pen_w = SUM_W'(pen_x_reg);
    assign bo_w  = SUM_W'(cfg.bold_on ? cfg.bold_overhang : '0);
    assign adv_w = SUM_W'(g_adv);

    // left edge against the pen before the bold shift
    assign z_min     = pen_w + SUM_W'(g_min_x);
    assign min_x_upd = (z_min < SUM_W'(min_x_reg)) ? sat_state(z_min) : min_x_reg;

    // right edge: bold shifts the pen, the box reaches the wider of advance and edge
    assign pen_bold  = sat_state(pen_w + bo_w);
    assign reach     = (g_adv > g_max_x) ? g_adv : g_max_x;
    assign z_max     = SUM_W'(pen_bold) + SUM_W'(reach);
    assign max_x_upd = (z_max > SUM_W'(max_x_reg)) ? sat_state(z_max) : max_x_reg;

    // both shifts are non-negative, so one clamp covers the pair
    assign pen_upd   = sat_state(pen_w + bo_w + adv_w);

    // vertical bounds
    assign min_y_upd = (ST_W'(g_min_y) < min_y_reg) ? ST_W'(g_min_y) : min_y_reg;
    assign max_y_upd = (ST_W'(g_max_y) > max_y_reg) ? ST_W'(g_max_y) : max_y_reg;

    // extent from the bounds including this glyph
    assign width_diff  = SUM_W'(max_x_upd) - SUM_W'(min_x_upd);
    assign height_diff = SUM_W'(max_y_upd) - SUM_W'(min_y_upd);
    assign text_width  = sat_out(width_diff);
    assign text_height = sat_out(height_diff);

    // next state: keep running, or clear at the end of a string
    always_comb begin
        pen_x_next = pen_x_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (en) begin
            if (last) begin
                pen_x_next = '0;
                min_x_next = '0;
                max_x_next = '0;
                min_y_next = '0;
                max_y_next = '0;
            end else begin
                pen_x_next = pen_upd;
                min_x_next = min_x_upd;
                max_x_next = max_x_upd;
                min_y_next = min_y_upd;
                max_y_next = max_y_upd;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg <= '0;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
        end else begin
            pen_x_reg <= pen_x_next;
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
        end
    end

endmodule

// File: hdl/tem_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tem_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       s_last_glyph,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [tem_pkg::OUT_W-1:0]  m_text_width,
    input logic [tem_pkg::OUT_W-1:0]  m_text_height
);

    // a held result keeps its value
    `TEM_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_text_width) && $stable(m_text_height), "result changed while stalled")

    // reset empties the result side
    `TEM_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")

    // a fresh result traces back to an accepted last glyph in the input register
    `TEM_ASSERT(a_result_source, $rose(m_valid) |-> $past(s_valid && s_ready && s_last_glyph, 2), "result without a last glyph")

    // with no result waiting the input side never backs up
    `TEM_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input stalled with result side empty")

endmodule

bind text_extent_measure tem_checker u_tem_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tem_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_COUNT     = 8;
    localparam int PHASE_ITEMS     = 170;
    localparam int HOLD_PHASE      = 2;
    localparam int PAUSE_PHASE     = 4;
    localparam int TAIL_ITEMS      = 130;
    localparam int SAT_GLYPHS      = 150;

    localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0]     CFG_SPARE_HI = '1;
    localparam logic [CFG_DATA_W-1:0]    STYLE_OFF    = '0;
    localparam logic [CFG_DATA_W-1:0]    STYLE_ON     = CFG_DATA_W'(1);
    localparam logic [CFG_DATA_W-1:0]    STYLE_MAX    = '1;
    localparam logic signed [META_W-1:0] BEARING_MIN  = {1'b1, {(META_W-1){1'b0}}};
    localparam logic signed [META_W-1:0] BEARING_MAX  = {1'b0, {(META_W-1){1'b1}}};
    localparam logic [DIM_W-1:0]         SIZE_MAX     = '1;

    localparam longint PX_ROUND  = (longint'(1) <<< FRAC_W) - 1;
    localparam longint STATE_HI  = (longint'(1) <<< (ST_W - 1)) - 1;
    localparam longint STATE_LO  = -(longint'(1) <<< (ST_W - 1));
    localparam longint EXTENT_HI = (longint'(1) <<< OUT_W) - 1;

    typedef struct {
        logic signed [META_W-1:0] bearing_x;
        logic [DIM_W-1:0]         glyph_width;
        logic signed [META_W-1:0] bearing_y;
        logic [DIM_W-1:0]         glyph_height;
        logic [DIM_W-1:0]         pen_advance;
        logic                     last_glyph;
    } glyph_t;

    typedef struct {
        logic [OUT_W-1:0] width;
        logic [OUT_W-1:0] height;
    } extent_t;

    // running pen and bounds of the string, and the extents still owed
    class extent_tracker;
        tem_cfg_t    style;
        longint      pen_x;
        longint      lo_x;
        longint      hi_x;
        longint      lo_y;
        longint      hi_y;
        extent_t     extents_due[$];
        int unsigned mismatches;

        function new();
            style = '0;
            mismatches = 0;
            clear_bounds();
        endfunction

        function void clear_bounds();
            pen_x = 0;
            lo_x = 0;
            hi_x = 0;
            lo_y = 0;
            hi_y = 0;
        endfunction

        function int pending();
            return extents_due.size();
        endfunction

        // round toward minus infinity, whole pixels
        function longint floor_px(logic signed [META_W-1:0] v);
            return longint'(v) >>> FRAC_W;
        endfunction

        // round up to whole pixels
        function longint ceil_px(logic [DIM_W-1:0] v);
            return (longint'(v) + PX_ROUND) >>> FRAC_W;
        endfunction

        function longint clamp_state(longint v);
            if (v > STATE_HI) begin
                return STATE_HI;
            end
            if (v < STATE_LO) begin
                return STATE_LO;
            end
            return v;
        endfunction

        function logic [OUT_W-1:0] clamp_extent(longint v);
            if (v < 0) begin
                return '0;
            end
            if (v > EXTENT_HI) begin
                return OUT_W'(EXTENT_HI);
            end
            return OUT_W'(v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BOLD_ON:       style.bold_on = data[0];
                CFG_ITALIC_ON:     style.italic_on = data[0];
                CFG_BOLD_OVERHANG: style.bold_overhang = data;
                CFG_ITALIC_BUMP:   style.italic_bump = data;
                default: ;
            endcase
        endfunction

        // fold one accepted glyph into the bounds
        function void note_glyph(glyph_t g);
            longint  box_lo_x;
            longint  box_hi_x;
            longint  box_lo_y;
            longint  box_hi_y;
            longint  adv;
            longint  reach;
            extent_t done;
            box_lo_x = floor_px(g.bearing_x);
            box_hi_x = box_lo_x + ceil_px(g.glyph_width);
            box_hi_y = floor_px(g.bearing_y);
            box_lo_y = box_hi_y - ceil_px(g.glyph_height);
            adv = ceil_px(g.pen_advance);
            if (style.bold_on) begin
                box_hi_x += longint'(style.bold_overhang);
            end
            if (style.italic_on) begin
                box_hi_x += longint'(style.italic_bump);
            end

            reach = pen_x + box_lo_x;
            if (reach < lo_x) begin
                lo_x = clamp_state(reach);
            end
            if (style.bold_on) begin
                pen_x = clamp_state(pen_x + longint'(style.bold_overhang));
            end
            reach = pen_x + ((adv > box_hi_x) ? adv : box_hi_x);
            if (reach > hi_x) begin
                hi_x = clamp_state(reach);
            end
            pen_x = clamp_state(pen_x + adv);
            if (box_lo_y < lo_y) begin
                lo_y = clamp_state(box_lo_y);
            end
            if (box_hi_y > hi_y) begin
                hi_y = clamp_state(box_hi_y);
            end

            // end of string: owe one extent, start afresh
            if (g.last_glyph) begin
                done.width = clamp_extent(hi_x - lo_x);
                done.height = clamp_extent(hi_y - lo_y);
                extents_due.push_back(done);
                clear_bounds();
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] extent mismatch: %s", $realtime, what);
        endtask

        task check_extent(logic [OUT_W-1:0] width, logic [OUT_W-1:0] height);
            extent_t want;
            if (extents_due.size() == 0) begin
                report_mismatch($sformatf("unexpected item %0d x %0d", width, height));
                return;
            end
            want = extents_due.pop_front();
            if (width !== want.width) begin
                report_mismatch($sformatf("width %0d, wanted %0d", width, want.width));
            end
            if (height !== want.height) begin
                report_mismatch($sformatf("height %0d, wanted %0d", height, want.height));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [META_W-1:0] s_bearing_x;
    logic [DIM_W-1:0]         s_glyph_width;
    logic signed [META_W-1:0] s_bearing_y;
    logic [DIM_W-1:0]         s_glyph_height;
    logic [DIM_W-1:0]         s_pen_advance;
    logic                     s_last_glyph;
    logic                     m_valid;
    logic                     m_ready;
    logic [OUT_W-1:0]         m_text_width;
    logic [OUT_W-1:0]         m_text_height;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    extent_tracker tracker;
    glyph_t        taken;
    bit            tx_idle_on = 1'b0;
    bit            rx_idle_on = 1'b0;
    bit            rx_hold_req = 1'b0;
    int            rx_stall_left = 0;
    int unsigned   cycle_count = 0;

    text_extent_measure dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bearing_x    (s_bearing_x),
        .s_glyph_width  (s_glyph_width),
        .s_bearing_y    (s_bearing_y),
        .s_glyph_height (s_glyph_height),
        .s_pen_advance  (s_pen_advance),
        .s_last_glyph   (s_last_glyph),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_text_width   (m_text_width),
        .m_text_height  (m_text_height),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // watch all three channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_extent(m_text_width, m_text_height);
            end
            if (s_valid && s_ready) begin
                taken.bearing_x = s_bearing_x;
                taken.glyph_width = s_glyph_width;
                taken.bearing_y = s_bearing_y;
                taken.glyph_height = s_glyph_height;
                taken.pen_advance = s_pen_advance;
                taken.last_glyph = s_last_glyph;
                tracker.note_glyph(taken);
            end
            if (cfg_valid && cfg_ready) begin
                tracker.set_reg(cfg_index, cfg_data);
            end
        end
    end

    // result receiver: random stall bursts, or one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_stall_left == 0 && rx_hold_req) begin
                rx_stall_left = HOLD_OFF_CYCLES;
                rx_hold_req = 1'b0;
            end else if (rx_stall_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
                rx_stall_left = $urandom_range(1, 11);
            end
            if (rx_stall_left > 0) begin
                m_ready = 1'b0;
                rx_stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    function automatic glyph_t make_glyph(logic signed [META_W-1:0] bx, logic [DIM_W-1:0] w,
                                          logic signed [META_W-1:0] by, logic [DIM_W-1:0] h,
                                          logic [DIM_W-1:0] adv, logic last);
        glyph_t g;
        g.bearing_x = bx;
        g.glyph_width = w;
        g.bearing_y = by;
        g.glyph_height = h;
        g.pen_advance = adv;
        g.last_glyph = last;
        return g;
    endfunction

    function automatic logic signed [META_W-1:0] rand_bearing();
        case ($urandom_range(0, 7))
            0: return BEARING_MIN;
            1: return BEARING_MAX;
            2, 3: return META_W'($urandom);
            default: return META_W'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SIZE_MAX;
            2, 3: return DIM_W'($urandom);
            default: return DIM_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_amount();
        case ($urandom_range(0, 3))
            0: return STYLE_OFF;
            1: return STYLE_MAX;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    task automatic tx_gap(input int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // offer one glyph and hold it until taken
    task automatic send_glyph(input glyph_t g);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            tx_gap($urandom_range(1, 11));
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_bearing_x = g.bearing_x;
        s_glyph_width = g.glyph_width;
        s_bearing_y = g.bearing_y;
        s_glyph_height = g.glyph_height;
        s_pen_advance = g.pen_advance;
        s_last_glyph = g.last_glyph;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_string(input int len);
        glyph_t g;
        for (int i = 0; i < len; i++) begin
            g = make_glyph(rand_bearing(), rand_size(), rand_bearing(), rand_size(),
                           rand_size(), i == len - 1);
            send_glyph(g);
        end
    endtask

    // random strings until at least the given number of glyphs went in
    task automatic send_strings(input int glyphs, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < glyphs) begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, max_len);
            send_string(len);
            sent += len;
        end
    endtask

    task automatic wait_for_extents();
        @(negedge aclk);
        s_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // drain, then let the pipeline empty before touching the style
    task automatic settle();
        wait_for_extents();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_style(input logic [CFG_DATA_W-1:0] bold, input logic [CFG_DATA_W-1:0] italic,
                             input logic [CFG_DATA_W-1:0] overhang,
                             input logic [CFG_DATA_W-1:0] bump, input bit spare);
        write_reg(CFG_BOLD_ON, bold);
        write_reg(CFG_ITALIC_ON, italic);
        write_reg(CFG_BOLD_OVERHANG, overhang);
        write_reg(CFG_ITALIC_BUMP, bump);
        // unused index, must leave the style alone
        if (spare) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), CFG_DATA_W'($urandom));
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // main sequence
    initial begin
        tracker = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_bearing_x = '0;
        s_glyph_width = '0;
        s_bearing_y = '0;
        s_glyph_height = '0;
        s_pen_advance = '0;
        s_last_glyph = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset style: rounding at the edges and the field extremes
        send_glyph(make_glyph(0, 0, 0, 0, 0, 1'b1));
        send_glyph(make_glyph(-1, 1, -1, 1, 1, 1'b0));
        send_glyph(make_glyph(BEARING_MAX, SIZE_MAX, BEARING_MAX, SIZE_MAX, SIZE_MAX, 1'b0));
        send_glyph(make_glyph(BEARING_MIN, 0, BEARING_MIN, SIZE_MAX, 0, 1'b1));
        send_glyph(make_glyph(64, 63, 65, 64, 127, 1'b1));
        send_glyph(make_glyph(-65, 1, -64, 0, 64, 1'b0));
        send_glyph(make_glyph(-64, 65, 63, 129, 0, 1'b1));
        settle();

        // both styles at full strength
        set_style(STYLE_MAX, STYLE_MAX, STYLE_MAX, STYLE_MAX, 1'b1);
        send_glyph(make_glyph(0, 0, 0, 0, 0, 1'b1));
        send_glyph(make_glyph(BEARING_MIN, SIZE_MAX, BEARING_MAX, 0, SIZE_MAX, 1'b0));
        send_glyph(make_glyph(BEARING_MAX, 0, BEARING_MIN, SIZE_MAX, 0, 1'b0));
        send_glyph(make_glyph(-100, 640, 700, 900, 64000, 1'b1));
        settle();

        // bold with no overhang, bump written but italic off
        set_style(STYLE_ON, STYLE_OFF, STYLE_OFF, STYLE_MAX, 1'b0);
        send_glyph(make_glyph(130, 200, -300, 50, 10, 1'b0));
        send_glyph(make_glyph(-500, 70, 90, 2000, 640, 1'b1));
        settle();

        // italic only, odd values in the upper enable bits
        set_style(~STYLE_ON, STYLE_MAX, STYLE_MAX, CFG_DATA_W'(128), 1'b1);
        send_glyph(make_glyph(3, 5, 7, 11, 13, 1'b0));
        send_glyph(make_glyph(-3, 500, -7, 11, 20000, 1'b0));
        send_glyph(make_glyph(BEARING_MIN, SIZE_MAX, BEARING_MIN, SIZE_MAX, SIZE_MAX, 1'b1));
        settle();

        // random phases, each under a fresh style
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_style(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), rand_amount(),
                      rand_amount(), $urandom_range(0, 2) == 0);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            if (phase == HOLD_PHASE) begin
                // receiver stops while short strings keep coming
                rx_hold_req = 1'b1;
                send_strings(60, 3);
                send_strings(PHASE_ITEMS - 60, 10);
            end else if (phase == PAUSE_PHASE) begin
                // sender stops until every owed extent is out
                send_strings(PHASE_ITEMS / 2, 10);
                wait_for_extents();
                send_strings(PHASE_ITEMS / 2, 10);
            end else begin
                send_strings(PHASE_ITEMS, 10);
            end
            settle();
        end

        // last part without idling: one long string that saturates the width, then random strings
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_style(STYLE_ON, STYLE_OFF, STYLE_MAX, rand_amount(), 1'b0);
        for (int i = 0; i < SAT_GLYPHS; i++) begin
            send_glyph(make_glyph(0, SIZE_MAX, 0, 0, SIZE_MAX, i == SAT_GLYPHS - 1));
        end
        send_strings(TAIL_ITEMS, 10);
        settle();

        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
